[hw/rtl/pis_pkg.sv]
`timescale 1ns / 1ps
// Shared types and constants for the permutation inverse shortcut block.
package pis_pkg;

  localparam int unsigned MAX_ENTRIES = 1024;
  localparam int unsigned IDX_W       = 10;
  localparam int unsigned LEN_W       = 11;
  // Shortcut entry: mark bit on top, back-link below.
  localparam int unsigned SC_W        = IDX_W + 1;

  localparam logic [LEN_W-1:0] MAX_LEN  = LEN_W'(MAX_ENTRIES);
  localparam logic [LEN_W-1:0] CLR_LAST = LEN_W'(MAX_ENTRIES - 1);

  localparam logic CFG_SAMPLE_RATE = 1'b0;
  localparam logic CFG_PERM_LENGTH = 1'b1;

  localparam logic [LEN_W-1:0] RST_SAMPLE_RATE = LEN_W'(16);
  localparam logic [LEN_W-1:0] RST_PERM_LENGTH = LEN_W'(1024);

  typedef enum logic [1:0] {
    KIND_LOAD  = 2'd0,
    KIND_BUILD = 2'd1,
    KIND_FWD   = 2'd2,
    KIND_INV   = 2'd3
  } kind_e;

  typedef enum logic [3:0] {
    ST_INIT_CLR,
    ST_IDLE,
    ST_FWD_RD,
    ST_FWD_CAP,
    ST_BLD_CLR1,
    ST_CHK_RD,
    ST_CHK_VIS,
    ST_CHK_UPD,
    ST_BLD_CLR2,
    ST_WLK_RD,
    ST_WLK_START,
    ST_WLK_STEP,
    ST_WLK_NEXT,
    ST_INV_RD,
    ST_INV_EVAL,
    ST_RESP
  } state_e;

  typedef struct packed {
    logic             we;
    logic [IDX_W-1:0] waddr;
    logic [IDX_W-1:0] wdata;
    logic [IDX_W-1:0] raddr;
  } perm_port_t;

  typedef struct packed {
    logic             we;
    logic [IDX_W-1:0] waddr;
    logic [SC_W-1:0]  wdata;
    logic [IDX_W-1:0] raddr;
  } sc_port_t;

  typedef struct packed {
    logic             we;
    logic [IDX_W-1:0] waddr;
    logic             wdata;
    logic [IDX_W-1:0] raddr;
  } vis_port_t;

  typedef struct packed {
    logic [IDX_W-1:0] answer;
    logic             answer_valid;
  } res_t;

endpackage

[hw/rtl/pis_ram.sv]
`timescale 1ns / 1ps
// Generic simple dual-port RAM: one write port, one read port with registered data.
module pis_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

[hw/rtl/pis_ctrl.sv]
`timescale 1ns / 1ps
// Sequencer for load, build, forward and inverse items over the three RAMs.
module pis_ctrl
  import pis_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_stall_o,
  input  kind_e            kind_i,
  input  logic [IDX_W-1:0] index_i,
  input  logic [IDX_W-1:0] entry_value_i,
  input  logic [LEN_W-1:0] sample_rate_i,
  input  logic [LEN_W-1:0] n_len_i,
  output res_t             res_o,
  output logic             res_valid_o,
  input  logic             res_ready_i,
  output perm_port_t       perm_o,
  input  logic [IDX_W-1:0] perm_rdata_i,
  output sc_port_t         sc_o,
  input  logic [SC_W-1:0]  sc_rdata_i,
  output vis_port_t        vis_o,
  input  logic             vis_rdata_i
);

  state_e           state_q, state_d;
  logic [LEN_W-1:0] ptr_q, ptr_d;
  logic [IDX_W-1:0] idx_q, idx_d;
  logic [IDX_W-1:0] pos_q, pos_d;
  logic [IDX_W-1:0] last_q, last_d;
  logic [LEN_W-1:0] count_q, count_d;
  logic [LEN_W-1:0] moves_q, moves_d;
  logic             added_q, added_d;
  logic             jumped_q, jumped_d;
  logic [IDX_W-1:0] ans_q, ans_d;
  logic             ok_q, ok_d;

  logic             in_range;
  logic [LEN_W-1:0] moves_inc;
  logic [IDX_W-1:0] ptr_idx;

  assign in_range  = ({1'b0, index_i} < n_len_i);
  assign moves_inc = moves_q + LEN_W'(1);
  assign ptr_idx   = ptr_q[IDX_W-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_INIT_CLR;
      ptr_q    <= '0;
      added_q  <= 1'b0;
      jumped_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      ptr_q    <= ptr_d;
      added_q  <= added_d;
      jumped_q <= jumped_d;
    end
  end

  always_ff @(posedge clk_i) begin
    idx_q   <= idx_d;
    pos_q   <= pos_d;
    last_q  <= last_d;
    count_q <= count_d;
    moves_q <= moves_d;
    ans_q   <= ans_d;
    ok_q    <= ok_d;
  end

  always_comb begin
    state_d     = state_q;
    ptr_d       = ptr_q;
    idx_d       = idx_q;
    pos_d       = pos_q;
    last_d      = last_q;
    count_d     = count_q;
    moves_d     = moves_q;
    added_d     = added_q;
    jumped_d    = jumped_q;
    ans_d       = ans_q;
    ok_d        = ok_q;
    perm_o      = '0;
    sc_o        = '0;
    vis_o       = '0;
    res_valid_o = 1'b0;
    in_stall_o  = (state_q != ST_IDLE);

    case (state_q)
      ST_INIT_CLR, ST_BLD_CLR1, ST_BLD_CLR2: begin
        // Sweep every entry: drop marks and visited bits.
        sc_o.we     = 1'b1;
        sc_o.waddr  = ptr_idx;
        vis_o.we    = 1'b1;
        vis_o.waddr = ptr_idx;
        if (ptr_q == CLR_LAST) begin
          ptr_d = '0;
          if (state_q == ST_INIT_CLR) begin
            state_d = ST_IDLE;
          end else if (state_q == ST_BLD_CLR1) begin
            state_d = ST_CHK_RD;
          end else begin
            state_d = ST_WLK_RD;
          end
        end else begin
          ptr_d = ptr_q + LEN_W'(1);
        end
      end

      ST_IDLE: begin
        if (in_valid_i) begin
          idx_d = index_i;
          ans_d = '0;
          ok_d  = 1'b0;
          case (kind_i)
            KIND_LOAD: begin
              perm_o.we    = in_range;
              perm_o.waddr = index_i;
              perm_o.wdata = entry_value_i;
              ok_d         = in_range;
              state_d      = ST_RESP;
            end
            KIND_BUILD: begin
              ptr_d   = '0;
              state_d = ST_BLD_CLR1;
            end
            KIND_FWD: begin
              state_d = in_range ? ST_FWD_RD : ST_RESP;
            end
            KIND_INV: begin
              pos_d    = index_i;
              moves_d  = '0;
              jumped_d = 1'b0;
              state_d  = in_range ? ST_INV_RD : ST_RESP;
            end
            default: begin
              state_d = ST_RESP;
            end
          endcase
        end
      end

      ST_FWD_RD: begin
        perm_o.raddr = idx_q;
        state_d      = ST_FWD_CAP;
      end

      ST_FWD_CAP: begin
        ans_d   = perm_rdata_i;
        ok_d    = 1'b1;
        state_d = ST_RESP;
      end

      ST_CHK_RD: begin
        if (ptr_q == n_len_i) begin
          ptr_d   = '0;
          state_d = ST_BLD_CLR2;
        end else begin
          perm_o.raddr = ptr_idx;
          state_d      = ST_CHK_VIS;
        end
      end

      ST_CHK_VIS: begin
        // Hold the image in pos while its visited bit is fetched.
        pos_d       = perm_rdata_i;
        vis_o.raddr = perm_rdata_i;
        if ({1'b0, perm_rdata_i} >= n_len_i) begin
          state_d = ST_RESP;
        end else begin
          state_d = ST_CHK_UPD;
        end
      end

      ST_CHK_UPD: begin
        if (vis_rdata_i) begin
          state_d = ST_RESP;
        end else begin
          vis_o.we    = 1'b1;
          vis_o.waddr = pos_q;
          vis_o.wdata = 1'b1;
          ptr_d       = ptr_q + LEN_W'(1);
          state_d     = ST_CHK_RD;
        end
      end

      ST_WLK_RD: begin
        if (ptr_q == n_len_i) begin
          ok_d    = 1'b1;
          state_d = ST_RESP;
        end else begin
          vis_o.raddr  = ptr_idx;
          perm_o.raddr = ptr_idx;
          state_d      = ST_WLK_START;
        end
      end

      ST_WLK_START: begin
        if (vis_rdata_i) begin
          ptr_d   = ptr_q + LEN_W'(1);
          state_d = ST_WLK_RD;
        end else begin
          vis_o.we    = 1'b1;
          vis_o.waddr = ptr_idx;
          vis_o.wdata = 1'b1;
          pos_d       = perm_rdata_i;
          count_d     = LEN_W'(1);
          added_d     = 1'b0;
          last_d      = ptr_idx;
          state_d     = ST_WLK_STEP;
        end
      end

      ST_WLK_STEP: begin
        if (pos_q == ptr_idx) begin
          // Cycle closed: if it holds a mark, link its start to the last mark.
          sc_o.we    = added_q;
          sc_o.waddr = ptr_idx;
          sc_o.wdata = {1'b1, last_q};
          ptr_d      = ptr_q + LEN_W'(1);
          state_d    = ST_WLK_RD;
        end else begin
          vis_o.we    = 1'b1;
          vis_o.waddr = pos_q;
          vis_o.wdata = 1'b1;
          if (count_q == sample_rate_i) begin
            sc_o.we    = 1'b1;
            sc_o.waddr = pos_q;
            sc_o.wdata = {1'b1, last_q};
            last_d     = pos_q;
            added_d    = 1'b1;
            count_d    = LEN_W'(1);
          end else begin
            count_d = count_q + LEN_W'(1);
          end
          perm_o.raddr = pos_q;
          state_d      = ST_WLK_NEXT;
        end
      end

      ST_WLK_NEXT: begin
        pos_d   = perm_rdata_i;
        state_d = ST_WLK_STEP;
      end

      ST_INV_RD: begin
        perm_o.raddr = pos_q;
        sc_o.raddr   = pos_q;
        state_d      = ST_INV_EVAL;
      end

      ST_INV_EVAL: begin
        if ({1'b0, perm_rdata_i} >= n_len_i) begin
          state_d = ST_RESP;
        end else if (perm_rdata_i == idx_q) begin
          ans_d   = pos_q;
          ok_d    = 1'b1;
          state_d = ST_RESP;
        end else if (!jumped_q && sc_rdata_i[SC_W-1]) begin
          // Jump back once, then walk on to the predecessor.
          if (({1'b0, sc_rdata_i[IDX_W-1:0]} >= n_len_i) || (moves_inc > n_len_i)) begin
            state_d = ST_RESP;
          end else begin
            pos_d    = sc_rdata_i[IDX_W-1:0];
            moves_d  = moves_inc;
            jumped_d = 1'b1;
            state_d  = ST_INV_RD;
          end
        end else if (moves_inc > n_len_i) begin
          state_d = ST_RESP;
        end else begin
          pos_d   = perm_rdata_i;
          moves_d = moves_inc;
          state_d = ST_INV_RD;
        end
      end

      ST_RESP: begin
        res_valid_o = 1'b1;
        if (res_ready_i) begin
          state_d = ST_IDLE;
        end
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  assign res_o.answer       = ans_q;
  assign res_o.answer_valid = ok_q;

  a_perm_write_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    perm_o.we |-> ({1'b0, perm_o.waddr} < n_len_i))
    else $error("permutation write beyond the active length");

  a_mark_only_in_walk: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (sc_o.we && sc_o.wdata[SC_W-1]) |-> (state_q == ST_WLK_STEP))
    else $error("mark written outside the cycle walk");

  a_inv_moves_bounded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_INV_RD) |-> (moves_q <= n_len_i))
    else $error("inverse walk exceeded its move budget");

endmodule

[hw/rtl/permutation_inverse_shortcuts.sv]
`timescale 1ns / 1ps
// Permutation store with shortcut back-links for fast inverse lookup.
//
// Input channel (in_valid_i / in_stall_o) takes one item per beat: kind_i selects
// load, build, forward lookup or inverse lookup; index_i and entry_value_i carry
// the operands. Output channel (out_valid_o / out_stall_i) returns one beat per
// item: answer_o and answer_valid_o. Config writes (cfg_we_i, cfg_index_i,
// cfg_wdata_i) set sample_rate and perm_length; write them only while no item
// is in flight. One item is in flight at a time; in_stall_o is high while it
// is worked on.
// Work per item: load writes one entry; forward reads one entry; inverse reads
//   one permutation and shortcut entry per walk move (moves below about 2 * sample_rate
//   after a build with a nonzero sample_rate); build clears all 1024 entries, checks the
//   permutation entry by entry, clears again, then walks each cycle from its start.
//   A forward or inverse lookup with an index out of range answers without a read.
// Every lookup and walk step reads RAMs that each have one read port with registered data.
// After reset a pass over all 1024 entries clears the shortcut and visited RAMs; no item
// is accepted during it. A finished result sits in the output register while
// the receiver stalls; the block may accept the next item meanwhile, but holds
// that item's result until the output register frees up.
module permutation_inverse_shortcuts
  import pis_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             cfg_we_i,
  input  logic             cfg_index_i,
  input  logic [LEN_W-1:0] cfg_wdata_i,
  input  logic             in_valid_i,
  output logic             in_stall_o,
  input  logic [1:0]       kind_i,
  input  logic [IDX_W-1:0] index_i,
  input  logic [IDX_W-1:0] entry_value_i,
  output logic             out_valid_o,
  input  logic             out_stall_i,
  output logic [IDX_W-1:0] answer_o,
  output logic             answer_valid_o
);

  logic [LEN_W-1:0] sample_rate_q;
  logic [LEN_W-1:0] perm_length_q;
  logic [LEN_W-1:0] n_len;

  res_t             res;
  logic             res_valid;
  logic             res_ready;
  res_t             out_res_q;
  logic             out_valid_q;

  perm_port_t       perm_port;
  sc_port_t         sc_port;
  vis_port_t        vis_port;
  logic [IDX_W-1:0] perm_rdata;
  logic [SC_W-1:0]  sc_rdata;
  logic             vis_rdata;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sample_rate_q <= RST_SAMPLE_RATE;
      perm_length_q <= RST_PERM_LENGTH;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        CFG_SAMPLE_RATE: sample_rate_q <= cfg_wdata_i;
        CFG_PERM_LENGTH: perm_length_q <= cfg_wdata_i;
        default: begin
        end
      endcase
    end
  end

  assign n_len = (perm_length_q > MAX_LEN) ? MAX_LEN : perm_length_q;

  pis_ctrl u_ctrl (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .kind_i        (kind_e'(kind_i)),
    .index_i       (index_i),
    .entry_value_i (entry_value_i),
    .sample_rate_i (sample_rate_q),
    .n_len_i       (n_len),
    .res_o         (res),
    .res_valid_o   (res_valid),
    .res_ready_i   (res_ready),
    .perm_o        (perm_port),
    .perm_rdata_i  (perm_rdata),
    .sc_o          (sc_port),
    .sc_rdata_i    (sc_rdata),
    .vis_o         (vis_port),
    .vis_rdata_i   (vis_rdata)
  );

  pis_ram #(.WIDTH(IDX_W), .DEPTH(MAX_ENTRIES)) u_perm_ram (
    .clk_i   (clk_i),
    .we_i    (perm_port.we),
    .waddr_i (perm_port.waddr),
    .wdata_i (perm_port.wdata),
    .raddr_i (perm_port.raddr),
    .rdata_o (perm_rdata)
  );

  pis_ram #(.WIDTH(SC_W), .DEPTH(MAX_ENTRIES)) u_sc_ram (
    .clk_i   (clk_i),
    .we_i    (sc_port.we),
    .waddr_i (sc_port.waddr),
    .wdata_i (sc_port.wdata),
    .raddr_i (sc_port.raddr),
    .rdata_o (sc_rdata)
  );

  pis_ram #(.WIDTH(1), .DEPTH(MAX_ENTRIES)) u_vis_ram (
    .clk_i   (clk_i),
    .we_i    (vis_port.we),
    .waddr_i (vis_port.waddr),
    .wdata_i (vis_port.wdata),
    .raddr_i (vis_port.raddr),
    .rdata_o (vis_rdata)
  );

  // Output register: load when empty or when the current beat leaves.
  assign res_ready = !out_valid_q || !out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (res_valid && res_ready) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_valid && res_ready) begin
      out_res_q <= res;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign answer_o       = out_res_q.answer;
  assign answer_valid_o = out_res_q.answer_valid;

  a_fail_gives_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !out_res_q.answer_valid) |-> (out_res_q.answer == '0))
    else $error("failed item carries a nonzero answer");

  a_result_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid && !res_ready) |=> (res_valid && $stable(res)))
    else $error("pending result dropped or changed before the output register took it");

  a_out_beat_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |=>
      (out_valid_o && $stable(answer_o) && $stable(answer_valid_o)))
    else $error("stalled output beat dropped or changed");

endmodule

[sim/tb_permutation_inverse_shortcuts.sv]
`timescale 1ns / 1ps
// Self-checking testbench for the permutation inverse shortcut block.
module tb_permutation_inverse_shortcuts;
  import pis_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 600000;
  localparam int unsigned HOLD_CYCLES = 400;
  localparam int unsigned NUM_PHASES  = 12;

  typedef struct {
    kind_e            kind;
    logic [IDX_W-1:0] idx;
    logic [IDX_W-1:0] val;
  } beat_t;

  logic             clk_i;
  logic             rst_n     = 1'b0;
  logic             cfg_we    = 1'b0;
  logic             cfg_index = CFG_SAMPLE_RATE;
  logic [LEN_W-1:0] cfg_wdata = '0;
  logic             in_valid  = 1'b0;
  kind_e            in_kind   = KIND_LOAD;
  logic [IDX_W-1:0] in_index  = '0;
  logic [IDX_W-1:0] in_value  = '0;
  logic             out_stall = 1'b0;
  logic             in_stall_o;
  logic             out_valid_o;
  logic [IDX_W-1:0] answer_o;
  logic             answer_valid_o;

  // Shadow copy of the block state
  logic [IDX_W-1:0] perm_mem [MAX_ENTRIES];
  logic [IDX_W-1:0] link_mem [MAX_ENTRIES];
  bit               mark_map [MAX_ENTRIES];
  int unsigned      rate_cfg = RST_SAMPLE_RATE;
  int unsigned      len_cfg  = RST_PERM_LENGTH;

  beat_t       pending_q [$];
  res_t        answer_q [$];
  beat_t       head_beat;
  res_t        want_res;
  int unsigned idle_mode     = 0;
  int unsigned fail_cnt      = 0;
  int unsigned beats_sent    = 0;
  int unsigned builds_sent   = 0;
  int unsigned inverse_sent  = 0;
  int unsigned answers_seen  = 0;
  int unsigned settings_cnt  = 0;
  int unsigned cycle_cnt     = 0;
  int unsigned hold_left     = 0;
  bit          hold_done     = 1'b0;

  int unsigned ph_rate   [NUM_PHASES] = '{1, 3, 0, 1024, 2047, 4, 2, 5, 7, 1, 13, 16};
  int unsigned ph_len    [NUM_PHASES] = '{12, 40, 20, 30, 5, 64, 1, 0, 100, 1024, 2047, 16};
  int unsigned ph_rounds [NUM_PHASES] = '{2, 1, 1, 1, 2, 1, 2, 1, 1, 1, 1, 1};

  permutation_inverse_shortcuts u_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_n),
    .cfg_we_i       (cfg_we),
    .cfg_index_i    (cfg_index),
    .cfg_wdata_i    (cfg_wdata),
    .in_valid_i     (in_valid),
    .in_stall_o     (in_stall_o),
    .kind_i         (in_kind),
    .index_i        (in_index),
    .entry_value_i  (in_value),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall),
    .answer_o       (answer_o),
    .answer_valid_o (answer_valid_o)
  );

  always begin
    clk_i = 1'b1;
    #5;
    clk_i = 1'b0;
    #5;
  end

  function automatic int unsigned active_len();
    return (len_cfg > MAX_ENTRIES) ? MAX_ENTRIES : len_cfg;
  endfunction

  // Check the permutation, then mark every rate-th position of each cycle and link it to the previous mark.
  function automatic bit rebuild_links();
    int unsigned n, pos, last, count;
    bit          seen [MAX_ENTRIES];
    bit          added;
    n = active_len();
    foreach (mark_map[i]) mark_map[i] = 1'b0;
    foreach (seen[i]) seen[i] = 1'b0;
    for (int k = 0; k < n; k++) begin
      if (perm_mem[k] >= n || seen[perm_mem[k]]) return 1'b0;
      seen[perm_mem[k]] = 1'b1;
    end
    foreach (seen[i]) seen[i] = 1'b0;
    for (int s = 0; s < n; s++) begin
      if (seen[s]) continue;
      seen[s] = 1'b1;
      added   = 1'b0;
      last    = s;
      count   = 1;
      pos     = perm_mem[s];
      while (pos != s) begin
        seen[pos] = 1'b1;
        if (count == rate_cfg) begin
          added         = 1'b1;
          mark_map[pos] = 1'b1;
          link_mem[pos] = IDX_W'(last);
          last          = pos;
          count         = 0;
        end
        pos = perm_mem[pos];
        count++;
      end
      if (added) begin
        mark_map[pos] = 1'b1;
        link_mem[pos] = IDX_W'(last);
      end
    end
    return 1'b1;
  endfunction

  // Walk forward; at the first mark take the back-link once, then walk on.
  function automatic bit find_preimage(int unsigned target, output logic [IDX_W-1:0] ans);
    int unsigned n, pos, nxt, moves;
    bit          jumped;
    n      = active_len();
    pos    = target;
    moves  = 0;
    jumped = 1'b0;
    ans    = '0;
    while (1'b1) begin
      nxt = perm_mem[pos];
      if (nxt >= n) return 1'b0;
      if (nxt == target) begin
        ans = IDX_W'(pos);
        return 1'b1;
      end
      if (!jumped && mark_map[pos]) begin
        jumped = 1'b1;
        pos    = link_mem[pos];
        moves++;
        if (pos >= n || moves > n) return 1'b0;
      end else begin
        pos = nxt;
        moves++;
        if (moves > n) return 1'b0;
      end
    end
    return 1'b0;
  endfunction

  function automatic res_t predict_beat(kind_e kind, logic [IDX_W-1:0] idx,
                                        logic [IDX_W-1:0] val);
    res_t             r;
    logic [IDX_W-1:0] pre;
    int unsigned      n;
    n = active_len();
    r = '0;
    case (kind)
      KIND_LOAD: begin
        if (idx < n) begin
          perm_mem[idx]  = val;
          r.answer_valid = 1'b1;
        end
      end
      KIND_BUILD: r.answer_valid = rebuild_links();
      KIND_FWD: begin
        if (idx < n) begin
          r.answer       = perm_mem[idx];
          r.answer_valid = 1'b1;
        end
      end
      KIND_INV: begin
        if (idx < n) begin
          r.answer_valid = find_preimage(idx, pre);
          r.answer       = pre;
        end
      end
      default: begin
      end
    endcase
    if (!r.answer_valid) r.answer = '0;
    return r;
  endfunction

  function automatic bit skip_cycle(int unsigned pct);
    return $urandom_range(99, 0) < pct;
  endfunction

  // Driver: hold a beat until accepted, then predict its answer.
  always @(posedge clk_i) begin
    if (rst_n) begin
      if (in_valid && !in_stall_o) begin
        answer_q = {answer_q, predict_beat(in_kind, in_index, in_value)};
        beats_sent++;
        if (in_kind == KIND_BUILD) builds_sent++;
        if (in_kind == KIND_INV) inverse_sent++;
      end
      if (!in_valid || !in_stall_o) begin
        if (pending_q.size() != 0 &&
            !skip_cycle(idle_mode == 0 ? 31 : (idle_mode == 1 ? 54 : 0))) begin
          head_beat = pending_q.pop_front();
          in_valid <= 1'b1;
          in_kind  <= head_beat.kind;
          in_index <= head_beat.idx;
          in_value <= head_beat.val;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Receiver stall, with one long hold-off to back the block up.
  always @(posedge clk_i) begin
    if (rst_n) begin
      if (hold_left != 0) begin
        out_stall <= 1'b1;
        hold_left <= hold_left - 1;
      end else if (!hold_done && answers_seen >= 120) begin
        hold_done <= 1'b1;
        hold_left <= HOLD_CYCLES;
        out_stall <= 1'b1;
      end else begin
        out_stall <= skip_cycle(idle_mode == 0 ? 54 : (idle_mode == 1 ? 31 : 0));
      end
    end
  end

  // Monitor
  always @(posedge clk_i) begin
    if (rst_n && out_valid_o && !out_stall) begin
      answers_seen++;
      if (answer_q.size() == 0) begin
        $error("result beat with nothing expected: answer %0d, answer_valid %0b",
               answer_o, answer_valid_o);
        fail_cnt++;
      end else begin
        want_res = answer_q.pop_front();
        if (answer_o !== want_res.answer) begin
          $error("answer mismatch: expected %0d, got %0d", want_res.answer, answer_o);
          fail_cnt++;
        end
        if (answer_valid_o !== want_res.answer_valid) begin
          $error("answer_valid mismatch: expected %0b, got %0b",
                 want_res.answer_valid, answer_valid_o);
          fail_cnt++;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_cnt++;
    if (cycle_cnt >= CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles, %0d answers outstanding", cycle_cnt,
               answer_q.size());
      $display("Some tests failed");
      $finish;
    end
  end

  task automatic post(kind_e kind, int unsigned idx, int unsigned val);
    beat_t b;
    b.kind = kind;
    b.idx  = IDX_W'(idx);
    b.val  = IDX_W'(val);
    pending_q = {pending_q, b};
  endtask

  function automatic int unsigned pick_index(int unsigned n);
    if (n == 0 || skip_cycle(10)) return $urandom_range(MAX_ENTRIES - 1, 0);
    return $urandom_range(n - 1, 0);
  endfunction

  // Load a shuffled permutation (sometimes broken), build, then look up.
  task automatic queue_round(int unsigned n);
    int unsigned img [MAX_ENTRIES];
    int unsigned j, t, looks;
    for (int i = 0; i < n; i++) img[i] = i;
    for (int i = int'(n) - 1; i > 0; i--) begin
      j      = $urandom_range(i, 0);
      t      = img[i];
      img[i] = img[j];
      img[j] = t;
    end
    if (n > 0 && skip_cycle(15)) begin
      j = $urandom_range(n - 1, 0);
      if (n > 1 && skip_cycle(50)) img[j] = img[(j + 1) % n];
      else img[j] = $urandom_range(MAX_ENTRIES - 1, n);
    end
    for (int i = 0; i < n; i++) begin
      post(KIND_LOAD, i, img[i]);
      if (skip_cycle(5)) post(KIND_LOAD, $urandom_range(MAX_ENTRIES - 1, n), $urandom);
    end
    post(KIND_BUILD, $urandom, $urandom);
    looks = $urandom_range(14, 6);
    for (int i = 0; i < looks; i++) begin
      t = $urandom_range(99, 0);
      // stray loads leave the shortcuts stale, which can send a walk astray
      if (t < 8 && n > 0) post(KIND_LOAD, $urandom_range(n - 1, 0), $urandom_range(n - 1, 0));
      else if (t < 12) post(KIND_BUILD, $urandom, $urandom);
      else if (t < 55) post(KIND_FWD, pick_index(n), $urandom);
      else post(KIND_INV, pick_index(n), $urandom);
    end
  endtask

  // Full length: keep to one cycle among the top positions, all of them loaded.
  task automatic queue_far_cycle();
    int unsigned pool [124];
    int unsigned j, t, m;
    for (int i = 0; i < 124; i++) pool[i] = 900 + i;
    for (int i = 123; i > 0; i--) begin
      j       = $urandom_range(i, 0);
      t       = pool[i];
      pool[i] = pool[j];
      pool[j] = t;
    end
    m = $urandom_range(24, 2);
    for (int i = 0; i < m; i++) post(KIND_LOAD, pool[i], pool[(i + 1) % m]);
    for (int i = 0; i < 16; i++) begin
      if (skip_cycle(50)) post(KIND_FWD, pool[$urandom_range(m - 1, 0)], $urandom);
      else post(KIND_INV, pool[$urandom_range(m - 1, 0)], $urandom);
    end
  endtask

  task automatic wait_drained();
    do @(negedge clk_i);
    while (pending_q.size() != 0 || in_valid || answer_q.size() != 0 || in_stall_o);
  endtask

  task automatic program_settings(int unsigned rate, int unsigned len);
    @(posedge clk_i);
    cfg_we    <= 1'b1;
    cfg_index <= CFG_SAMPLE_RATE;
    cfg_wdata <= LEN_W'(rate);
    @(posedge clk_i);
    cfg_index <= CFG_PERM_LENGTH;
    cfg_wdata <= LEN_W'(len);
    @(posedge clk_i);
    cfg_we   <= 1'b0;
    rate_cfg = rate;
    len_cfg  = len;
    settings_cnt++;
  endtask

  initial begin
    repeat (10) @(posedge clk_i);
    rst_n <= 1'b1;

    // Reset settings: a short cycle through both ends of the index range
    post(KIND_LOAD, 0, 1023);
    post(KIND_LOAD, 1023, 1008);
    post(KIND_LOAD, 1008, 1012);
    post(KIND_LOAD, 1012, 1019);
    post(KIND_LOAD, 1019, 1010);
    post(KIND_LOAD, 1010, 1016);
    post(KIND_LOAD, 1016, 0);
    post(KIND_FWD, 1023, 0);
    post(KIND_INV, 0, 1023);
    post(KIND_INV, 1023, 0);
    wait_drained();

    // One permutation cycle through all active entries, marked at sample rate 2
    program_settings(2, 8);
    post(KIND_LOAD, 0, 5);
    post(KIND_LOAD, 5, 2);
    post(KIND_LOAD, 2, 7);
    post(KIND_LOAD, 7, 4);
    post(KIND_LOAD, 4, 1);
    post(KIND_LOAD, 1, 6);
    post(KIND_LOAD, 6, 3);
    post(KIND_LOAD, 3, 0);
    post(KIND_BUILD, 0, 0);
    post(KIND_INV, 0, 0);
    post(KIND_INV, 3, 0);
    post(KIND_FWD, 7, 0);
    post(KIND_LOAD, 8, 1023);
    post(KIND_FWD, 1023, 0);
    post(KIND_LOAD, 3, 9);
    post(KIND_BUILD, 1023, 1023);
    post(KIND_INV, 5, 0);
    post(KIND_LOAD, 3, 0);
    post(KIND_BUILD, 0, 0);
    post(KIND_LOAD, 6, 6);
    post(KIND_INV, 2, 0);
    wait_drained();

    for (int p = 0; p < NUM_PHASES; p++) begin
      idle_mode = (p < 4) ? 0 : ((p < 8) ? 1 : 2);
      program_settings(ph_rate[p], ph_len[p]);
      for (int r = 0; r < ph_rounds[p]; r++) begin
        if (ph_len[p] >= MAX_ENTRIES) queue_far_cycle();
        else queue_round(ph_len[p]);
      end
      wait_drained();
    end

    repeat (40) @(posedge clk_i);
    $display("Checked %0d answers for %0d beats (%0d builds, %0d inverse lookups)",
             answers_seen, beats_sent, builds_sent, inverse_sent);
    $display("Covered %0d register settings, a %0d-cycle output hold-off and %0d cycles",
             settings_cnt, HOLD_CYCLES, cycle_cnt);
    if (fail_cnt == 0 && answer_q.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

[files.f]
hw/rtl/pis_pkg.sv
hw/rtl/pis_ram.sv
hw/rtl/pis_ctrl.sv
hw/rtl/permutation_inverse_shortcuts.sv
sim/tb_permutation_inverse_shortcuts.sv
